### rtl/core/modular_inverse_via_totient_top_assert.svh
// assertion macros for the modular inverse block
// used by modular_inverse_via_totient_top
`ifndef MODULAR_INVERSE_VIA_TOTIENT_TOP_ASSERT_SVH
`define MODULAR_INVERSE_VIA_TOTIENT_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MIVT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define MIVT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/core/mivt_pkg.sv
// package for the modular inverse block: widths and sequencer states
// no dependencies
`timescale 1ns / 1ps
package mivt_pkg;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TWO,
    ST_ODD,
    ST_DIV,
    ST_PHIMUL,
    ST_TAIL,
    ST_POWSTART,
    ST_POWSTEP,
    ST_MOD,
    ST_DONE
  } state_t;

  // what the shared reduction unit result is used for
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TRIAL,
    OP_REDUCE_V,
    OP_ACC,
    OP_SQR
  } op_t;
endpackage

### rtl/core/mivt_if.sv
// valid/ready channel interface carrying one payload word
// depends on mivt_pkg for the default width
`timescale 1ns / 1ps
interface mivt_if #(
  parameter int unsigned W = mivt_pkg::DATA_W
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/modular_inverse_via_totient_top.sv
// modular inverse by euler's theorem: value^(phi(m)-1) mod m
// depends on mivt_pkg, mivt_if and the assertion header
`timescale 1ns / 1ps
// One item in, one result out; the input is not ready while an item is in
// work. The totient of the modulus is found by trial division on the first
// item after a modulus write and then cached. Products come from combinational
// multipliers, and every reduction runs on one shared restoring divider that
// retires one quotient bit per cycle. A power takes up to 2*WIDTH+1 steps
// (reduce the value, then one square per exponent bit and one multiply per
// set bit), each step one division on the shared divider. Trial division
// tries every odd candidate up to the square root of the remaining cofactor,
// each by one division. Modulus 0 or 1 answers 0, going straight from idle
// to the done state. A finished result waits in its own register, so the
// next item can start before the result is taken.
`include "modular_inverse_via_totient_top_assert.svh"
module modular_inverse_via_totient_top #(
  parameter int unsigned WIDTH = mivt_pkg::DATA_W
) (
  input  logic   clk,
  input  logic   rst_n,
  mivt_if.sink   in_ch,
  mivt_if.source out_ch,
  mivt_if.sink   cfg_ch
);
  localparam int unsigned W2 = 2 * WIDTH;
  localparam int unsigned CW = $clog2(W2 + 1);

  mivt_pkg::state_t state_r, state_nxt;
  mivt_pkg::op_t    op_r, op_nxt;

  logic [WIDTH-1:0] mod_r;
  logic [WIDTH-1:0] phi_r, phi_nxt;
  logic             tv_r, tv_nxt;
  logic [WIDTH-1:0] rest_r, rest_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic [WIDTH-1:0] pw_r, pw_nxt;
  logic             first_r, first_nxt;
  logic [WIDTH-1:0] v_r, v_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] e_r, e_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;
  logic             ov_r, ov_nxt;
  // shared divider: num / den, one quotient bit a cycle
  logic [W2-1:0]    num_r, num_nxt;
  logic [W2-1:0]    q_r, q_nxt;
  logic [W2:0]      rem_r, rem_nxt;
  logic [W2-1:0]    den_r, den_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  logic [W2:0]      trial;
  logic [W2-1:0]    dd;
  logic [W2-1:0]    prod;
  logic [WIDTH-1:0] rem_w;
  logic [WIDTH-1:0] q_w;

  assign trial  = {rem_r[W2-1:0], num_r[W2-1]};
  assign dd     = d_r * d_r;
  assign rem_w  = rem_r[WIDTH-1:0];
  assign q_w    = q_r[WIDTH-1:0];

  assign in_ch.ready  = (state_r == mivt_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = res_r;

  always_comb begin
    unique case (op_nxt)
      mivt_pkg::OP_ACC: prod = acc_r * b_r;
      mivt_pkg::OP_SQR: prod = b_r * b_r;
      default:          prod = {{WIDTH{1'b0}}, v_r};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    phi_nxt   = phi_r;
    tv_nxt    = tv_r;
    rest_nxt  = rest_r;
    d_nxt     = d_r;
    pw_nxt    = pw_r;
    first_nxt = first_r;
    v_nxt     = v_r;
    acc_nxt   = acc_r;
    b_nxt     = b_r;
    e_nxt     = e_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r;
    num_nxt   = num_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (state_r)
      mivt_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          v_nxt = in_ch.data[WIDTH-1:0];
          if (mod_r <= {{(WIDTH-1){1'b0}}, 1'b1}) begin
            acc_nxt   = '0;
            state_nxt = mivt_pkg::ST_DONE;
          end else if (tv_r) begin
            state_nxt = mivt_pkg::ST_POWSTART;
          end else begin
            rest_nxt  = mod_r;
            phi_nxt   = {{(WIDTH-1){1'b0}}, 1'b1};
            pw_nxt    = {{(WIDTH-1){1'b0}}, 1'b1};
            first_nxt = 1'b1;
            state_nxt = mivt_pkg::ST_TWO;
          end
        end
      end
      mivt_pkg::ST_TWO: begin
        // strip factors of two by shifting
        if (!rest_r[0]) begin
          rest_nxt = rest_r >> 1;
          if (first_r) first_nxt = 1'b0;
          else pw_nxt = pw_r << 1;
        end else begin
          phi_nxt   = pw_r;
          d_nxt     = WIDTH'(3);
          state_nxt = mivt_pkg::ST_ODD;
        end
      end
      mivt_pkg::ST_ODD: begin
        if (dd <= {{WIDTH{1'b0}}, rest_r}) begin
          num_nxt   = {{WIDTH{1'b0}}, rest_r};
          den_nxt   = {{WIDTH{1'b0}}, d_r};
          rem_nxt   = '0;
          q_nxt     = '0;
          cnt_nxt   = '0;
          op_nxt    = mivt_pkg::OP_TRIAL;
          first_nxt = 1'b1;
          pw_nxt    = {{(WIDTH-1){1'b0}}, 1'b1};
          state_nxt = mivt_pkg::ST_DIV;
        end else begin
          state_nxt = mivt_pkg::ST_TAIL;
        end
      end
      mivt_pkg::ST_DIV: begin
        // restoring division step on the shared unit
        if (cnt_r == CW'(W2)) begin
          if (op_r == mivt_pkg::OP_TRIAL) begin
            if (rem_r == '0) begin
              rest_nxt = q_w;
              // pw collects (d-1)*d^(e-1) for this prime
              if (first_r) pw_nxt = d_r - WIDTH'(1);
              else pw_nxt = WIDTH'(pw_r * d_r);
              first_nxt = 1'b0;
              num_nxt = {{WIDTH{1'b0}}, q_w};
              rem_nxt = '0;
              q_nxt   = '0;
              cnt_nxt = '0;
            end else if (!first_r) begin
              state_nxt = mivt_pkg::ST_PHIMUL;
            end else begin
              d_nxt     = d_r + WIDTH'(2);
              state_nxt = mivt_pkg::ST_ODD;
            end
          end else begin
            state_nxt = mivt_pkg::ST_MOD;
          end
        end else begin
          if (trial >= {1'b0, den_r}) begin
            rem_nxt = trial - {1'b0, den_r};
            q_nxt   = {q_r[W2-2:0], 1'b1};
          end else begin
            rem_nxt = trial;
            q_nxt   = {q_r[W2-2:0], 1'b0};
          end
          num_nxt = num_r << 1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      mivt_pkg::ST_PHIMUL: begin
        phi_nxt   = WIDTH'(phi_r * pw_r);
        d_nxt     = d_r + WIDTH'(2);
        state_nxt = mivt_pkg::ST_ODD;
      end
      mivt_pkg::ST_TAIL: begin
        if (rest_r > {{(WIDTH-1){1'b0}}, 1'b1})
          phi_nxt = WIDTH'(phi_r * (rest_r - WIDTH'(1)));
        tv_nxt    = 1'b1;
        state_nxt = mivt_pkg::ST_POWSTART;
      end
      mivt_pkg::ST_POWSTART: begin
        acc_nxt = {{(WIDTH-1){1'b0}}, 1'b1};
        e_nxt   = phi_r - WIDTH'(1);
        op_nxt  = mivt_pkg::OP_REDUCE_V;
        num_nxt = {{WIDTH{1'b0}}, v_r};
        den_nxt = {{WIDTH{1'b0}}, mod_r};
        rem_nxt = '0;
        q_nxt   = '0;
        cnt_nxt = '0;
        state_nxt = mivt_pkg::ST_DIV;
      end
      mivt_pkg::ST_MOD: begin
        unique case (op_r)
          mivt_pkg::OP_REDUCE_V: b_nxt = rem_w;
          mivt_pkg::OP_ACC:      acc_nxt = rem_w;
          mivt_pkg::OP_SQR: begin
            b_nxt = rem_w;
            e_nxt = e_r >> 1;
          end
          default: ;
        endcase
        state_nxt = mivt_pkg::ST_POWSTEP;
      end
      mivt_pkg::ST_POWSTEP: begin
        if (e_r == '0) begin
          state_nxt = mivt_pkg::ST_DONE;
        end else begin
          if (e_r[0] && op_r != mivt_pkg::OP_ACC) op_nxt = mivt_pkg::OP_ACC;
          else op_nxt = mivt_pkg::OP_SQR;
          rem_nxt   = '0;
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = mivt_pkg::ST_DIV;
        end
      end
      mivt_pkg::ST_DONE: begin
        // wait here while the previous result is still held
        if (!ov_r || out_ch.ready) begin
          res_nxt   = acc_r;
          ov_nxt    = 1'b1;
          state_nxt = mivt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mivt_pkg::ST_IDLE;
    endcase
    if (state_r == mivt_pkg::ST_POWSTEP && e_r != '0) num_nxt = prod;
    if (cfg_ch.valid) tv_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mivt_pkg::ST_IDLE;
      op_r    <= mivt_pkg::OP_NONE;
      tv_r    <= 1'b0;
      ov_r    <= 1'b0;
      mod_r   <= {{(WIDTH-1){1'b0}}, 1'b1};
      phi_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      tv_r    <= tv_nxt;
      ov_r    <= ov_nxt;
      phi_r   <= phi_nxt;
      if (cfg_ch.valid) mod_r <= cfg_ch.data[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rest_r  <= rest_nxt;
    d_r     <= d_nxt;
    pw_r    <= pw_nxt;
    first_r <= first_nxt;
    v_r     <= v_nxt;
    acc_r   <= acc_nxt;
    b_r     <= b_nxt;
    e_r     <= e_nxt;
    res_r   <= res_nxt;
    num_r   <= num_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    cnt_r   <= cnt_nxt;
  end

  `MIVT_ASSERT_IMP(a_busy_not_ready, state_r != mivt_pkg::ST_IDLE, !in_ch.ready)
  `MIVT_ASSERT_NXT(a_out_holds, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
  `MIVT_ASSERT_IMP(a_cnt_bound, state_r == mivt_pkg::ST_DIV, cnt_r <= CW'(W2))
  `MIVT_ASSERT_NXT(a_cfg_clears, cfg_ch.valid, !tv_r)
endmodule
